FILE: rtl/core/gcmd_pkg.sv
// gcmd_pkg: sizes, field types, codes and controller/datapath bundles
// for the grid cell min distance store; no dependencies
`default_nettype none

package gcmd_pkg;

    localparam int GRID_SIDE      = 64;
    localparam int SLOTS_PER_CELL = 8;
    localparam int PATH_COUNT     = 256;

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int AXIS_W     = $clog2(GRID_SIDE);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int SLOT_W     = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int FILL_W     = $clog2(SLOTS_PER_CELL + 1);

    localparam int INDEX_W   = 6;
    localparam int PATH_W    = 8;
    localparam int DIST_W    = 16;
    localparam int COORD_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_METER = 2'd2;

    localparam logic signed [COORD_W-1:0] ORIGIN_RESET = -16'sd256;
    localparam logic [COORD_W-1:0]        CPM_RESET    = 16'd512;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [PATH_W-1:0] path;
        logic [DIST_W-1:0] distance;
    } slot_t;

    typedef slot_t [SLOTS_PER_CELL-1:0] row_t;

    typedef struct packed {
        logic              load;
        logic              map;
        logic              read;
        logic              decide;
        logic              clear;
        logic [CELL_W-1:0] clr_addr;
        logic              out_load;
        logic [SLOT_W-1:0] slot_idx;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic              list;
        logic [FILL_W-1:0] count;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/gcmd_ctrl.sv
// gcmd_ctrl: sequencer for clear sweep, lookup, decide and result beats
// depends on gcmd_pkg
`default_nettype none

module gcmd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output gcmd_pkg::cmd_t      cmd,
    input  wire gcmd_pkg::stat_t stat
);
    import gcmd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_READ,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CELL_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              is_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_last   = !stat.list || ((FILL_W'(idx_reg) + FILL_W'(1)) == stat.count);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.clr_addr  = clr_addr_reg;
        cmd.slot_idx  = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear     = 1'b1;
                clr_addr_next = CELL_W'(clr_addr_reg + CELL_W'(1));
                if (clr_addr_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                idx_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.last = is_last;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = SLOT_W'(idx_reg + SLOT_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gcmd_dpath.sv
// gcmd_dpath: config registers, position to cell mapping, fill and slot
// memories, update decision and result register; depends on gcmd_pkg
`default_nettype none

module gcmd_dpath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire gcmd_pkg::cmd_t                        cmd,
    output gcmd_pkg::stat_t                            stat,
    input  wire logic                                  cfg_write,
    input  wire logic [gcmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gcmd_pkg::COORD_W-1:0]          cfg_data,
    input  wire logic                                  op,
    input  wire logic [gcmd_pkg::INDEX_W-1:0]          cell_col,
    input  wire logic [gcmd_pkg::INDEX_W-1:0]          cell_row,
    input  wire logic [gcmd_pkg::PATH_W-1:0]           path_id,
    input  wire logic [gcmd_pkg::DIST_W-1:0]           path_distance,
    input  wire logic signed [gcmd_pkg::COORD_W-1:0]   probe_x,
    input  wire logic signed [gcmd_pkg::COORD_W-1:0]   probe_y,
    output logic                                       found,
    output logic [gcmd_pkg::PATH_W-1:0]                entry_path,
    output logic [gcmd_pkg::DIST_W-1:0]                entry_distance,
    output logic [gcmd_pkg::STATUS_W-1:0]              status,
    output logic                                       last
);
    import gcmd_pkg::*;

    // configuration
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [COORD_W-1:0]        cpm_reg;

    // captured beat
    logic                  op_reg;
    logic [INDEX_W-1:0]    col_reg;
    logic [INDEX_W-1:0]    row_reg;
    logic [PATH_W-1:0]     path_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [COORD_W:0]      dx_reg, dy_reg;
    logic [COORD_W:0]      dx_next, dy_next;

    // mapping
    logic [PROD_W-1:0]     prod_x_reg, prod_y_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic [COORD_W-1:0]    qx, qy;
    logic                  in_grid;
    logic [AXIS_W-1:0]     col_sel, row_sel;
    logic [CELL_W-1:0]     cell_addr;
    logic [CELL_W-1:0]     cell_reg;
    logic                  oob_reg;

    // storage
    logic [FILL_W-1:0]     fill_mem [CELL_COUNT];
    row_t                  row_mem  [CELL_COUNT];
    logic [FILL_W-1:0]     fill_q_reg;
    row_t                  row_q_reg;

    // decision
    logic [FILL_W-1:0]     n;
    logic [SLOTS_PER_CELL-1:0] hit;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_idx;
    logic [DIST_W-1:0]     kept_dist;
    row_t                  row_wdata;
    logic                  row_we;
    logic [FILL_W-1:0]     fill_wdata;
    logic                  fill_we;
    logic                  res_found_next;
    logic [PATH_W-1:0]     res_path_next;
    logic [DIST_W-1:0]     res_dist_next;
    status_t               res_status_next;
    logic                  list_next;

    logic                  res_found_reg;
    logic [PATH_W-1:0]     res_path_reg;
    logic [DIST_W-1:0]     res_dist_reg;
    status_t               res_status_reg;
    logic                  list_reg;
    logic [FILL_W-1:0]     count_reg;

    // result register
    logic                  found_reg;
    logic [PATH_W-1:0]     entry_path_reg;
    logic [DIST_W-1:0]     entry_distance_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_RESET;
            origin_y_reg <= ORIGIN_RESET;
            cpm_reg      <= CPM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:        origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y:        origin_y_reg <= cfg_data;
                CFG_CELLS_PER_METER: cpm_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign dx_next = {probe_x[COORD_W-1], probe_x} - {origin_x_reg[COORD_W-1], origin_x_reg};
    assign dy_next = {probe_y[COORD_W-1], probe_y} - {origin_y_reg[COORD_W-1], origin_y_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            col_reg  <= cell_col;
            row_reg  <= cell_row;
            path_reg <= path_id;
            dist_reg <= path_distance;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
        if (cmd.map)
        begin
            prod_x_reg <= PROD_W'(dx_reg[COORD_W-1:0]) * PROD_W'(cpm_reg);
            prod_y_reg <= PROD_W'(dy_reg[COORD_W-1:0]) * PROD_W'(cpm_reg);
            neg_x_reg  <= dx_reg[COORD_W];
            neg_y_reg  <= dy_reg[COORD_W];
        end
    end

    // cell selection from the registered products or the update indexes
    assign qx = prod_x_reg[PROD_W-1:COORD_W];
    assign qy = prod_y_reg[PROD_W-1:COORD_W];

    always_comb
    begin
        if (op_reg)
        begin
            in_grid = !neg_x_reg && !neg_y_reg
                   && (32'(qx) < GRID_SIDE) && (32'(qy) < GRID_SIDE);
            col_sel = AXIS_W'(qx);
            row_sel = AXIS_W'(qy);
        end
        else
        begin
            in_grid = (32'(col_reg) < GRID_SIDE) && (32'(row_reg) < GRID_SIDE)
                   && (32'(path_reg) < PATH_COUNT);
            col_sel = AXIS_W'(col_reg);
            row_sel = AXIS_W'(row_reg);
        end
        cell_addr = CELL_W'(32'(row_sel) * GRID_SIDE + 32'(col_sel));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            cell_reg <= cell_addr;
            oob_reg  <= !in_grid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            fill_mem[cmd.clr_addr] <= '0;
        end
        else if (fill_we)
        begin
            fill_mem[cell_reg] <= fill_wdata;
        end
        if (cmd.read)
        begin
            fill_q_reg <= fill_mem[cell_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[cell_reg] <= row_wdata;
        end
        if (cmd.read)
        begin
            row_q_reg <= row_mem[cell_addr];
        end
    end

    // match search and update decision
    always_comb
    begin
        n = (32'(fill_q_reg) > SLOTS_PER_CELL) ? FILL_W'(SLOTS_PER_CELL) : fill_q_reg;
        for (int i = 0; i < SLOTS_PER_CELL; i++)
        begin
            hit[i] = (FILL_W'(i) < n) && (row_q_reg[i].path == path_reg);
        end
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS_PER_CELL - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
        kept_dist = (dist_reg < row_q_reg[hit_idx].distance) ? dist_reg
                                                             : row_q_reg[hit_idx].distance;

        row_wdata       = row_q_reg;
        row_we          = 1'b0;
        fill_wdata      = FILL_W'(n + FILL_W'(1));
        fill_we         = 1'b0;
        res_found_next  = 1'b0;
        res_path_next   = '0;
        res_dist_next   = '0;
        res_status_next = ST_OK;
        list_next       = 1'b0;

        if (oob_reg)
        begin
            res_status_next = ST_OUTSIDE;
        end
        else if (op_reg)
        begin
            list_next = (n != '0);
        end
        else if (hit_any)
        begin
            row_wdata[hit_idx].distance = kept_dist;
            row_we                      = cmd.decide;
            res_found_next              = 1'b1;
            res_path_next               = path_reg;
            res_dist_next               = kept_dist;
        end
        else if (32'(n) >= SLOTS_PER_CELL)
        begin
            res_status_next = ST_FULL;
        end
        else
        begin
            row_wdata[SLOT_W'(n)].path     = path_reg;
            row_wdata[SLOT_W'(n)].distance = dist_reg;
            row_we                         = cmd.decide;
            fill_we                        = cmd.decide;
            res_found_next                 = 1'b1;
            res_path_next                  = path_reg;
            res_dist_next                  = dist_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_found_reg  <= res_found_next;
            res_path_reg   <= res_path_next;
            res_dist_reg   <= res_dist_next;
            res_status_reg <= res_status_next;
            list_reg       <= list_next;
            count_reg      <= n;
        end
    end

    assign stat.list  = list_reg;
    assign stat.count = count_reg;

    // output beat register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (list_reg)
            begin
                found_reg          <= 1'b1;
                entry_path_reg     <= row_q_reg[cmd.slot_idx].path;
                entry_distance_reg <= row_q_reg[cmd.slot_idx].distance;
                status_reg         <= ST_OK;
            end
            else
            begin
                found_reg          <= res_found_reg;
                entry_path_reg     <= res_path_reg;
                entry_distance_reg <= res_dist_reg;
                status_reg         <= res_status_reg;
            end
            last_reg <= cmd.last;
        end
    end

    assign found          = found_reg;
    assign entry_path     = entry_path_reg;
    assign entry_distance = entry_distance_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/grid_cell_min_distance_store.sv
// grid_cell_min_distance_store: top level joining the sequencer and the datapath
// depends on gcmd_pkg, gcmd_ctrl, gcmd_dpath
//
//   channel  handshake              beat contents
//   in       in_valid / in_ready    op, cell_col, cell_row, path_id, path_distance,
//                                   probe_x, probe_y
//   out      out_valid / out_ready  found, entry_path, entry_distance, status, last
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// after reset a sweep clears the 4096 cell fill counts, with in_ready low
// an update gives one result beat, a query one per stored pair (n pairs, min 1)
// lookup pass: capture, map (multiply), registered memory read, decide, emit
// result beats go out one a cycle through an output register; out_ready low holds them
// cfg_ready is always high
`default_nettype none

module grid_cell_min_distance_store (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  op,
    input  wire logic [gcmd_pkg::INDEX_W-1:0]          cell_col,
    input  wire logic [gcmd_pkg::INDEX_W-1:0]          cell_row,
    input  wire logic [gcmd_pkg::PATH_W-1:0]           path_id,
    input  wire logic [gcmd_pkg::DIST_W-1:0]           path_distance,
    input  wire logic signed [gcmd_pkg::COORD_W-1:0]   probe_x,
    input  wire logic signed [gcmd_pkg::COORD_W-1:0]   probe_y,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       found,
    output logic [gcmd_pkg::PATH_W-1:0]                entry_path,
    output logic [gcmd_pkg::DIST_W-1:0]                entry_distance,
    output logic [gcmd_pkg::STATUS_W-1:0]              status,
    output logic                                       last,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gcmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gcmd_pkg::COORD_W-1:0]          cfg_data
);
    import gcmd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    gcmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gcmd_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .op             (op),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .path_id        (path_id),
        .path_distance  (path_distance),
        .probe_x        (probe_x),
        .probe_y        (probe_y),
        .found          (found),
        .entry_path     (entry_path),
        .entry_distance (entry_distance),
        .status         (status),
        .last           (last)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for grid_cell_min_distance_store; keeps its own copy of the
// per-cell path/distance lists and checks every result beat; depends on gcmd_pkg and the rtl

module tb_top;
    import gcmd_pkg::*;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_PATTERN  = 1;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOT_CELLS   = 3;
    localparam int PATH_POOL   = 12;

    typedef struct {
        logic                      op;
        logic [INDEX_W-1:0]        col;
        logic [INDEX_W-1:0]        row;
        logic [PATH_W-1:0]         path;
        logic [DIST_W-1:0]         distance;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } req_t;

    typedef struct {
        logic              found;
        logic [PATH_W-1:0] path;
        logic [DIST_W-1:0] distance;
        status_t           st;
        logic              last;
    } beat_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      op;
    logic [INDEX_W-1:0]        cell_col;
    logic [INDEX_W-1:0]        cell_row;
    logic [PATH_W-1:0]         path_id;
    logic [DIST_W-1:0]         path_distance;
    logic signed [COORD_W-1:0] probe_x;
    logic signed [COORD_W-1:0] probe_y;
    logic                      out_valid;
    logic                      out_ready;
    logic                      found;
    logic [PATH_W-1:0]         entry_path;
    logic [DIST_W-1:0]         entry_distance;
    logic [STATUS_W-1:0]       status;
    logic                      last;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [COORD_W-1:0]        cfg_data;

    // local copy of the cell store and the grid registers
    int unsigned               cell_count [CELL_COUNT];
    logic [PATH_W-1:0]         cell_path [CELL_COUNT][SLOTS_PER_CELL];
    logic [DIST_W-1:0]         cell_dist [CELL_COUNT][SLOTS_PER_CELL];
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [COORD_W-1:0]        cpm;

    beat_t             pending_beats [$];
    int                err_count;
    int                rx_mode;
    int                hold_req;
    int                idle_cycles;
    int                hot_col [HOT_CELLS];
    int                hot_row [HOT_CELLS];
    logic [PATH_W-1:0] path_pool [PATH_POOL];

    grid_cell_min_distance_store dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .cell_col       (cell_col),
        .cell_row       (cell_row),
        .path_id        (path_id),
        .path_distance  (path_distance),
        .probe_x        (probe_x),
        .probe_y        (probe_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .entry_path     (entry_path),
        .entry_distance (entry_distance),
        .status         (status),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic beat_t mk_beat(logic f, logic [PATH_W-1:0] p, logic [DIST_W-1:0] d,
                                      status_t s, logic l);
        beat_t b;
        b.found    = f;
        b.path     = p;
        b.distance = d;
        b.st       = s;
        b.last     = l;
        return b;
    endfunction

    function automatic void add_expected(beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic bit map_axis(logic signed [COORD_W-1:0] p,
                                    logic signed [COORD_W-1:0] o, output int idx);
        longint d;
        longint q;
        d = longint'(p) - longint'(o);
        if (d < 0)
            return 0;
        q = (d * longint'(cpm)) >>> 16;
        if (q >= GRID_SIDE)
            return 0;
        idx = int'(q);
        return 1;
    endfunction

    function automatic void compute_cell_response(req_t r);
        int c;
        int k;
        int n;
        int col;
        int row;
        if (r.op == OP_UPDATE)
        begin
            c = int'(r.row) * GRID_SIDE + int'(r.col);
            n = cell_count[c];
            for (k = 0; k < n; k++)
            begin
                if (cell_path[c][k] == r.path)
                begin
                    if (r.distance < cell_dist[c][k])
                        cell_dist[c][k] = r.distance;
                    add_expected(mk_beat(1'b1, r.path, cell_dist[c][k], ST_OK, 1'b1));
                    return;
                end
            end
            if (n >= SLOTS_PER_CELL)
            begin
                add_expected(mk_beat(1'b0, '0, '0, ST_FULL, 1'b1));
                return;
            end
            cell_path[c][n] = r.path;
            cell_dist[c][n] = r.distance;
            cell_count[c]   = n + 1;
            add_expected(mk_beat(1'b1, r.path, r.distance, ST_OK, 1'b1));
            return;
        end
        if (!map_axis(r.px, org_x, col) || !map_axis(r.py, org_y, row))
        begin
            add_expected(mk_beat(1'b0, '0, '0, ST_OUTSIDE, 1'b1));
            return;
        end
        c = row * GRID_SIDE + col;
        n = cell_count[c];
        if (n == 0)
        begin
            add_expected(mk_beat(1'b0, '0, '0, ST_OK, 1'b1));
            return;
        end
        for (k = 0; k < n; k++)
            add_expected(mk_beat(1'b1, cell_path[c][k], cell_dist[c][k], ST_OK,
                                 k == n - 1));
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.op       = 1'($urandom_range(0, 1));
        r.col      = INDEX_W'($urandom);
        r.row      = INDEX_W'($urandom);
        r.path     = PATH_W'($urandom);
        r.distance = DIST_W'($urandom);
        r.px       = COORD_W'($urandom);
        r.py       = COORD_W'($urandom);
        return r;
    endfunction

    function automatic req_t upd(int col, int row, int path, int distance);
        req_t r;
        r          = rand_req();
        r.op       = OP_UPDATE;
        r.col      = col[INDEX_W-1:0];
        r.row      = row[INDEX_W-1:0];
        r.path     = path[PATH_W-1:0];
        r.distance = distance[DIST_W-1:0];
        return r;
    endfunction

    function automatic req_t qry(int x, int y);
        req_t r;
        r    = rand_req();
        r.op = OP_QUERY;
        r.px = x[COORD_W-1:0];
        r.py = y[COORD_W-1:0];
        return r;
    endfunction

    // position somewhere inside cell idx along one axis, random when unreachable
    function automatic logic signed [COORD_W-1:0] aim_probe(int idx,
                                                            logic signed [COORD_W-1:0] o);
        longint d;
        longint span;
        longint p;
        if (cpm == 0)
            return COORD_W'($urandom);
        d    = (longint'(idx) * 65536 + longint'(cpm) - 1) / longint'(cpm);
        span = 65536 / longint'(cpm);
        d    = d + $urandom_range(0, int'(span) - 1);
        p    = longint'(o) + d;
        if (p > 32767)
            return COORD_W'($urandom);
        return p[COORD_W-1:0];
    endfunction

    task automatic send_item(req_t r);
        @(negedge clk);
        in_valid      <= 1'b1;
        op            <= r.op;
        cell_col      <= r.col;
        cell_row      <= r.row;
        path_id       <= r.path;
        path_distance <= r.distance;
        probe_x       <= r.px;
        probe_y       <= r.py;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        compute_cell_response(r);
    endtask

    task automatic idle_input(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_input(1);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_ORIGIN_X:        org_x = val;
            CFG_ORIGIN_Y:        org_y = val;
            CFG_CELLS_PER_METER: cpm   = val;
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int ox, int oy, int c);
        wait_drained();
        write_reg(CFG_ORIGIN_X, ox[COORD_W-1:0]);
        write_reg(CFG_ORIGIN_Y, oy[COORD_W-1:0]);
        write_reg(CFG_CELLS_PER_METER, c[COORD_W-1:0]);
    endtask

    function automatic req_t pick_traffic_item();
        int   sel;
        int   h;
        int   d;
        req_t r;
        sel = $urandom_range(0, 99);
        h   = $urandom_range(0, HOT_CELLS - 1);
        d   = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
        if (sel < 45)
            r = upd(hot_col[h], hot_row[h], path_pool[$urandom_range(0, PATH_POOL - 1)], d);
        else if (sel < 75)
        begin
            r    = rand_req();
            r.op = OP_QUERY;
            r.px = aim_probe(hot_col[h], org_x);
            r.py = aim_probe(hot_row[h], org_y);
        end
        else
        begin
            r    = rand_req();
            r.op = (sel < 85) ? OP_UPDATE : OP_QUERY;
        end
        return r;
    endfunction

    task automatic run_phase(int count, bit gaps, int mode);
        int burst_left;
        burst_left = 0;
        rx_mode    = mode;
        repeat (count)
        begin
            if (gaps && burst_left == 0)
            begin
                idle_input($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end
            send_item(pick_traffic_item());
            if (burst_left > 0)
                burst_left--;
        end
        wait_drained();
    endtask

    // append, shorter replaces, longer and equal keep, full cell drops
    task automatic test_update_rules();
        int k;
        rx_mode = RX_PATTERN;
        send_item(upd(0, 0, 0, 0));
        send_item(upd(63, 63, 255, 65535));
        send_item(upd(63, 63, 255, 100));
        send_item(upd(63, 63, 255, 200));
        send_item(upd(63, 63, 255, 100));
        for (k = 1; k <= SLOTS_PER_CELL + 1; k++)
            send_item(upd(5, 7, k, 1000 + k));
        send_item(upd(5, 7, 3, 5));
        wait_drained();
    endtask

    // reset grid: origin -1.0 m, two cells per meter, 128 units per cell
    task automatic test_query_mapping();
        send_item(qry(-256, -256));
        send_item(qry(384, 640));
        send_item(qry(7935, 7935));
        send_item(qry(7936, 0));
        send_item(qry(-257, 0));
        send_item(qry(0, 0));
        send_item(qry(32767, -32768));
        wait_drained();
    endtask

    // output held off while input keeps coming, then the sender waits for all beats
    task automatic test_backpressure();
        int   k;
        req_t r;
        rx_mode  = RX_ALWAYS;
        hold_req = 1;
        for (k = 0; k < 20; k++)
        begin
            if (k % 2 == 0)
                r = qry(384, 640);
            else
            begin
                r    = rand_req();
                r.op = OP_UPDATE;
            end
            send_item(r);
        end
        wait_drained();
        rx_mode = RX_PATTERN;
    endtask

    task automatic test_register_extremes();
        set_grid(-32768, -32768, 1);
        send_item(qry($urandom_range(0, 65535), $urandom_range(0, 65535)));
        send_item(qry(32767, 32767));
        send_item(qry(-32768, -32768));
        set_grid(32767, 32767, 65535);
        send_item(qry(32767, 32767));
        send_item(qry(32766, 32767));
        send_item(qry(-32768, -32768));
        set_grid(0, 0, 0);
        send_item(qry(0, 0));
        send_item(qry(-1, 0));
        send_item(qry(32767, 32767));
        send_item(upd(0, 0, 77, 9));
        send_item(qry(100, 5000));
        set_grid(-32768, 0, 65535);
        send_item(qry(-32768, 63));
        send_item(qry(-32768, 64));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int k;
        hot_col[0] = 5;
        hot_row[0] = 7;
        for (k = 1; k < HOT_CELLS; k++)
        begin
            hot_col[k] = $urandom_range(0, GRID_SIDE - 1);
            hot_row[k] = $urandom_range(0, GRID_SIDE - 1);
        end
        for (k = 0; k < PATH_POOL; k++)
            path_pool[k] = PATH_W'($urandom);
        set_grid(-256, -256, 512);
        run_phase(15, 1'b0, RX_ALWAYS);
        set_grid(-int'($urandom_range(0, 2048)), -int'($urandom_range(0, 2048)),
                 $urandom_range(128, 4096));
        run_phase(15, 1'b1, RX_PATTERN);
        set_grid(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                 $urandom_range(4096, 65535));
        run_phase(15, 1'b1, RX_PATTERN);
    endtask

    // receiver: always ready, own run-length stall pattern, or a long hold-off on request
    initial
    begin
        int  hold_left;
        int  run_left;
        bit  run_ready;
        hold_left = 0;
        run_left  = 0;
        run_ready = 1'b1;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (rx_mode == RX_ALWAYS)
                out_ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = ($urandom_range(0, 2) != 0);
                    run_left  = run_ready ? $urandom_range(1, 16) : $urandom_range(1, 10);
                end
                run_left--;
                out_ready <= run_ready;
            end
        end
    end

    task automatic report_field(string name, logic [31:0] e, logic [31:0] a);
        $display("%0t mismatch on %s, expected %0d, actual %0d", $time, name, e, a);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t unexpected beat, expected none, actual found %b path %0d",
                         $time, found, entry_path);
                $display("    dist %0d code %0d last %b", entry_distance, status, last);
                err_count++;
            end
            else
            begin
                e = pending_beats.pop_front();
                if (found !== e.found)
                    report_field("found", 32'(e.found), 32'(found));
                if (entry_path !== e.path)
                    report_field("entry_path", 32'(e.path), 32'(entry_path));
                if (entry_distance !== e.distance)
                    report_field("entry_distance", 32'(e.distance), 32'(entry_distance));
                if (status !== e.st)
                    report_field("result code", 32'(e.st), 32'(status));
                if (last !== e.last)
                    report_field("last", 32'(e.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_UPDATE;
        cell_col      = '0;
        cell_row      = '0;
        path_id       = '0;
        path_distance = '0;
        probe_x       = '0;
        probe_y       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ORIGIN_X;
        cfg_data      = '0;
        org_x         = ORIGIN_RESET;
        org_y         = ORIGIN_RESET;
        cpm           = CPM_RESET;
        err_count     = 0;
        idle_cycles   = 0;
        hold_req      = 0;
        rx_mode       = RX_PATTERN;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_update_rules();
        test_query_mapping();
        test_backpressure();
        test_register_extremes();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
